// File: rtl/sorted_address_object_table_top_macros.svh
// ----------------------------------------------------------------------------
// Sorted address/object table assertion macros
// Concurrent assertion shorthands clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_ADDRESS_OBJECT_TABLE_TOP_MACROS_SVH
`define SORTED_ADDRESS_OBJECT_TABLE_TOP_MACROS_SVH

`ifndef SYNTH

// Check that cons holds whenever ante holds.
`define SAT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that expr holds on every rising clock edge.
`define SAT_ASSERT_HOLD(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`else

`define SAT_ASSERT_IMPLY(lbl, ante, cons, msg)
`define SAT_ASSERT_HOLD(lbl, expr, msg)

`endif

`endif

// File: rtl/sat_pkg.sv
// ----------------------------------------------------------------------------
// Sorted address/object table package
// Request, response and entry types plus command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sat_pkg;

  localparam int unsigned TABLE_DEPTH_DEFAULT = 64;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NULL     = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] object_handle;
    logic [31:0] address;
    logic [7:0]  type_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_handle;
  } rsp_t;

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] handle;
    logic [7:0]  type_tag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// File: rtl/sat_ram.sv
// ----------------------------------------------------------------------------
// Sorted address/object table RAM
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/sorted_address_object_table_top.sv
// ----------------------------------------------------------------------------
// Sorted address/object table
// Address-ordered table of (address, handle, type) entries with insert,
// remove-by-handle and find-by-address-and-type requests.
// ----------------------------------------------------------------------------
// One request at a time, one response per request. Entries live in a single
// RAM with one write and one registered read port, and a small sequencer walks
// it one entry per cycle. A find stops at the matching entry or once addresses
// pass the key, and otherwise scans every entry. An insert moves later entries
// up before writing the new one, or writes it at the end when none move. A
// remove moves later entries down, or moves none when the match is the last
// entry or the handle is absent. Rejected requests (null handle, full table,
// unused code) skip the scan and go straight to the response. Each request
// returns to idle before the next request is taken. The RAM read port sets
// the pace: every scanned or moved entry costs one read. A finished response
// waits in an output register and does not block the start of the next
// request.
`default_nettype none

module sorted_address_object_table_top #(
  parameter int unsigned TableDepth = sat_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire sat_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sat_pkg::rsp_t      out_rsp_o
);

  import sat_pkg::*;

  `include "sorted_address_object_table_top_macros.svh"

  localparam int unsigned IDX_W = $clog2(TableDepth);
  localparam int unsigned CNT_W = $clog2(TableDepth + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  req_t               req_q, req_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   issue_q, issue_d;
  logic               chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]   chk_idx_q, chk_idx_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [IDX_W-1:0]   src_q, src_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;
  logic [1:0]         res_status_q, res_status_d;
  logic [15:0]        res_handle_q, res_handle_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_rsp_q, out_rsp_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;
  entry_t             new_entry;
  logic               hit;
  logic               stop_miss;
  logic               is_insert;

  sat_ram #(
    .Width (ENTRY_W),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign new_entry = '{address: req_q.address, handle: req_q.object_handle,
                       type_tag: req_q.type_tag};
  assign is_insert = (req_q.command == CMD_INSERT);
  assign ram_raddr = (state_q == S_SHIFT) ? src_q : issue_q[IDX_W-1:0];

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Compare the entry read last cycle against the request.
  always_comb begin
    hit       = 1'b0;
    stop_miss = 1'b0;
    unique case (req_q.command)
      CMD_INSERT: hit = (rd_entry.address >= req_q.address);
      CMD_REMOVE: hit = (rd_entry.handle == req_q.object_handle);
      CMD_FIND: begin
        hit       = (rd_entry.address == req_q.address) &&
                    (rd_entry.type_tag == req_q.type_tag);
        stop_miss = (rd_entry.address > req_q.address);
      end
      default: begin
        hit       = 1'b0;
        stop_miss = 1'b0;
      end
    endcase
    hit       = hit && chk_vld_q;
    stop_miss = stop_miss && chk_vld_q;
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    count_d      = count_q;
    issue_d      = issue_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    pos_d        = pos_q;
    rem_d        = rem_q;
    src_d        = src_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    out_valid_d  = out_valid_q;
    out_rsp_d    = out_rsp_q;
    ram_we       = 1'b0;
    ram_waddr    = pend_idx_q;
    ram_wdata    = ram_rdata;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d        = in_req_i;
          issue_d      = '0;
          res_handle_d = '0;
          res_status_d = ST_OK;
          unique case (in_req_i.command)
            CMD_INSERT: begin
              if (in_req_i.object_handle == '0) begin
                res_status_d = ST_NULL;
                state_d      = S_RESP;
              end else if (count_q == CNT_W'(TableDepth)) begin
                res_status_d = ST_FULL;
                state_d      = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_REMOVE: begin
              if (in_req_i.object_handle == '0) begin
                res_status_d = ST_NULL;
                state_d      = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_FIND: state_d = S_SCAN;
            default:  state_d = S_RESP;
          endcase
        end
      end

      S_SCAN: begin
        priority if (hit) begin
          pos_d = CNT_W'(chk_idx_q);
          unique case (req_q.command)
            CMD_INSERT: begin
              rem_d   = count_q - CNT_W'(chk_idx_q);
              src_d   = IDX_W'(count_q - CNT_W'(1));
              state_d = S_SHIFT;
            end
            CMD_REMOVE: begin
              rem_d   = count_q - CNT_W'(1) - CNT_W'(chk_idx_q);
              src_d   = IDX_W'(CNT_W'(chk_idx_q) + CNT_W'(1));
              state_d = S_SHIFT;
            end
            default: begin
              res_status_d = ST_OK;
              res_handle_d = rd_entry.handle;
              state_d      = S_RESP;
            end
          endcase
        end else if (stop_miss || (issue_q == count_q)) begin
          if (is_insert) begin
            // Append at the end: nothing to move.
            pos_d   = count_q;
            rem_d   = '0;
            state_d = S_SHIFT;
          end else begin
            res_status_d = ST_NOTFOUND;
            state_d      = S_RESP;
          end
        end else begin
          chk_vld_d = 1'b1;
          chk_idx_d = issue_q[IDX_W-1:0];
          issue_d   = issue_q + CNT_W'(1);
        end
      end

      S_SHIFT: begin
        // Write back the entry read last cycle, one slot over.
        ram_we = pend_q;
        if (rem_q != '0) begin
          pend_d = 1'b1;
          rem_d  = rem_q - CNT_W'(1);
          if (is_insert) begin
            pend_idx_d = src_q + IDX_W'(1);
            src_d      = src_q - IDX_W'(1);
          end else begin
            pend_idx_d = src_q - IDX_W'(1);
            src_d      = src_q + IDX_W'(1);
          end
        end else if (!pend_q) begin
          res_status_d = ST_OK;
          res_handle_d = '0;
          state_d      = S_RESP;
          if (is_insert) begin
            ram_we    = 1'b1;
            ram_waddr = pos_q[IDX_W-1:0];
            ram_wdata = new_entry;
            count_d   = count_q + CNT_W'(1);
          end else begin
            count_d = count_q - CNT_W'(1);
          end
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rsp_d   = '{status: res_status_q, result_handle: res_handle_q};
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      chk_vld_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      chk_vld_q   <= chk_vld_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    issue_q      <= issue_d;
    chk_idx_q    <= chk_idx_d;
    pos_q        <= pos_d;
    rem_q        <= rem_d;
    src_q        <= src_d;
    pend_idx_q   <= pend_idx_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    out_rsp_q    <= out_rsp_d;
  end

  `SAT_ASSERT_HOLD(a_count_bound, count_q <= CNT_W'(TableDepth), "entry count above depth")
  `SAT_ASSERT_IMPLY(a_write_in_range, ram_we, CNT_W'(ram_waddr) <= count_q, "write past table end")
  `SAT_ASSERT_IMPLY(a_count_step, count_q != $past(count_q), (count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1)), "count jumped by more than one")
  `SAT_ASSERT_IMPLY(a_handle_ok_only, out_valid_o && (out_rsp_o.result_handle != '0), out_rsp_o.status == ST_OK, "handle returned with error status")

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted address/object table testbench
// Drives insert, remove, find and unused-code requests through the valid/ready
// request channel. A scoreboard keeps a shadow copy of the sorted table and
// checks every response in order. Idle gaps and output stalls are random.
// ----------------------------------------------------------------------------
module tb_top;
  import sat_pkg::*;

  localparam int unsigned DEPTH      = TABLE_DEPTH_DEFAULT;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam int          IDLE_LIMIT = 5000;
  localparam int          PHASE_LEN  = 100;
  localparam int          NUM_PHASES = 14;
  localparam int          MIX        = 0;
  localparam int          FILL       = 1;
  localparam int          DRAIN      = 2;

  class table_scoreboard;
    logic [31:0] ent_addr [TABLE_DEPTH_DEFAULT];
    logic [15:0] ent_handle [TABLE_DEPTH_DEFAULT];
    logic [7:0]  ent_type [TABLE_DEPTH_DEFAULT];
    int          count;
    rsp_t        pending [$];
    int          errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 50) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Apply a request to the shadow table and queue the response it yields.
    function void note_request(req_t r);
      rsp_t rsp;
      int   pos;
      int   k;
      rsp = '0;
      rsp.status = ST_OK;
      case (r.command)
        CMD_INSERT: begin
          if (r.object_handle == 16'd0) begin
            rsp.status = ST_NULL;
          end else if (count >= DEPTH) begin
            rsp.status = ST_FULL;
          end else begin
            pos = 0;
            while (pos < count && ent_addr[pos] < r.address) pos++;
            for (k = count; k > pos; k--) begin
              ent_addr[k]   = ent_addr[k-1];
              ent_handle[k] = ent_handle[k-1];
              ent_type[k]   = ent_type[k-1];
            end
            ent_addr[pos]   = r.address;
            ent_handle[pos] = r.object_handle;
            ent_type[pos]   = r.type_tag;
            count++;
          end
        end
        CMD_REMOVE: begin
          if (r.object_handle == 16'd0) begin
            rsp.status = ST_NULL;
          end else begin
            pos = 0;
            while (pos < count && ent_handle[pos] != r.object_handle) pos++;
            if (pos == count) begin
              rsp.status = ST_NOTFOUND;
            end else begin
              for (k = pos + 1; k < count; k++) begin
                ent_addr[k-1]   = ent_addr[k];
                ent_handle[k-1] = ent_handle[k];
                ent_type[k-1]   = ent_type[k];
              end
              count--;
            end
          end
        end
        CMD_FIND: begin
          rsp.status = ST_NOTFOUND;
          // Scan in address order; stop once addresses pass the key.
          for (pos = 0; pos < count && ent_addr[pos] <= r.address; pos++) begin
            if (ent_addr[pos] == r.address && ent_type[pos] == r.type_tag) begin
              rsp.status        = ST_OK;
              rsp.result_handle = ent_handle[pos];
              break;
            end
          end
        end
        default: ;
      endcase
      pending.push_back(rsp);
    endfunction

    task check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("response with none outstanding: status %0d handle %h",
                                  got.status, got.result_handle));
      end else begin
        want = pending.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.result_handle !== want.result_handle)
          report_mismatch($sformatf("result_handle %h, want %h",
                                    got.result_handle, want.result_handle));
      end
    endtask
  endclass

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  req_t  in_req_i;
  logic  out_valid_o;
  logic  out_ready_i;
  rsp_t  out_rsp_o;

  table_scoreboard book;
  bit              calm;
  int              quiet_cycles;

  sorted_address_object_table_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one; none while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'd0;
    if (r < 70) return 16'($urandom_range(1, 48));
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35 && book.count > 0) return book.ent_addr[$urandom_range(0, book.count - 1)];
    if (r < 70) return 32'($urandom_range(0, 31));
    if (r < 75) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    return 32'($urandom);
  endfunction

  function automatic logic [7:0] pick_type();
    if ($urandom_range(0, 99) < 70) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic req_t random_request(int mode);
    req_t r;
    int   pick;
    int   idx;
    int   ins_w;
    int   rem_w;
    r.command       = CMD_INSERT;
    r.object_handle = 16'($urandom);
    r.address       = 32'($urandom);
    r.type_tag      = 8'($urandom);
    // Noise: any code, any payload.
    if ($urandom_range(0, 99) < 5) begin
      r.command = 2'($urandom);
      return r;
    end
    case (mode)
      FILL:    begin ins_w = 80; rem_w = 10; end
      DRAIN:   begin ins_w = 15; rem_w = 70; end
      default: begin ins_w = 40; rem_w = 30; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < ins_w) begin
      r.command       = CMD_INSERT;
      r.object_handle = pick_handle();
      r.address       = pick_address();
      r.type_tag      = pick_type();
    end else if (pick < ins_w + rem_w) begin
      r.command = CMD_REMOVE;
      if (book.count > 0 && $urandom_range(0, 99) < 75)
        r.object_handle = book.ent_handle[$urandom_range(0, book.count - 1)];
      else
        r.object_handle = pick_handle();
    end else begin
      r.command = CMD_FIND;
      if (book.count > 0 && $urandom_range(0, 99) < 70) begin
        idx        = $urandom_range(0, book.count - 1);
        r.address  = book.ent_addr[idx];
        r.type_tag = ($urandom_range(0, 3) == 0) ? pick_type() : book.ent_type[idx];
      end else begin
        r.address  = pick_address();
        r.type_tag = pick_type();
      end
    end
    return r;
  endfunction

  function automatic req_t make_request(logic [1:0] cmd, logic [15:0] h,
                                        logic [31:0] a, logic [7:0] t);
    req_t r;
    r.command       = cmd;
    r.object_handle = h;
    r.address       = a;
    r.type_tag      = t;
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic issue(req_t r);
    int gap;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_request(r);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Hold off the sender until every response is back.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (book.pending.size() != 0) @(negedge clk_i);
  endtask

  // Output side: random stalls on out_ready_i.
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) book.check_response(out_rsp_o);
    end
  end

  // Watchdog: end the run if no request or response moves for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int n;
    int mode;
    book       = new();
    calm       = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty table, null handles, extremes, duplicates, early stop.
    issue(make_request(CMD_FIND,   16'h0000, 32'h0000_0000, 8'h00));
    issue(make_request(CMD_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
    issue(make_request(CMD_INSERT, 16'h0000, 32'h1234_5678, 8'h12));
    issue(make_request(CMD_REMOVE, 16'h0000, 32'h0000_0000, 8'h00));
    issue(make_request(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
    issue(make_request(CMD_INSERT, 16'h0001, 32'h0000_0000, 8'h00));
    issue(make_request(CMD_INSERT, 16'h8000, 32'h8000_0000, 8'h80));
    issue(make_request(CMD_INSERT, 16'h0002, 32'h8000_0000, 8'h81));
    issue(make_request(CMD_INSERT, 16'h0001, 32'h0000_0010, 8'h01));
    issue(make_request(CMD_FIND,   16'h0000, 32'h8000_0000, 8'h80));
    issue(make_request(CMD_FIND,   16'h0000, 32'h8000_0000, 8'h81));
    issue(make_request(CMD_FIND,   16'h0000, 32'h8000_0000, 8'h7F));
    issue(make_request(CMD_FIND,   16'h0000, 32'hFFFF_FFFF, 8'hFF));
    issue(make_request(CMD_FIND,   16'h0000, 32'h0000_0000, 8'h00));
    issue(make_request(CMD_FIND,   16'h0000, 32'h0000_0005, 8'h00));
    issue(make_request(CMD_FIND,   16'hABCD, 32'h0000_0010, 8'h01));
    issue(make_request(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
    issue(make_request(CMD_REMOVE, 16'h0001, 32'h0000_0000, 8'h00));
    issue(make_request(CMD_FIND,   16'h0000, 32'h0000_0010, 8'h01));
    issue(make_request(CMD_REMOVE, 16'h0001, 32'hFFFF_FFFF, 8'hFF));
    issue(make_request(CMD_REMOVE, 16'h0001, 32'h0000_0000, 8'h00));
    issue(make_request(CMD_REMOVE, 16'hFFFF, 32'h0000_0000, 8'h00));
    issue(make_request(CMD_REMOVE, 16'h8000, 32'h0000_0000, 8'h00));
    issue(make_request(CMD_REMOVE, 16'h0002, 32'h0000_0000, 8'h00));
    settle();

    // Random: cycle through mixed, fill-to-full and drain phases.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        1:       mode = FILL;
        3:       mode = DRAIN;
        default: mode = MIX;
      endcase
      calm = (phase % 5 == 3);
      for (n = 0; n < PHASE_LEN; n++) issue(random_request(mode));
      if (phase % 3 == 0) settle();
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (book.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
